[design/rrte_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrte_pkg
// shared types, constants and codes of the route table engine
// ----------------------------------------------------------------------------
package rrte_pkg;

    localparam int TABLE_DEPTH        = 64;
    localparam int NUM_IFACES         = 4;
    localparam int ENTRIES_PER_PACKET = 25;

    localparam int IDX_W   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int PKT_W   = $clog2(ENTRIES_PER_PACKET + 1);
    localparam int ROUTE_W = 64 + 64 + 8 + 16 + 8 + 2;

    localparam logic [7:0] INFINITY_METRIC = 8'd16;
    localparam logic [7:0] NEXTHOP_METRIC  = 8'hff;

    localparam logic [1:0] FUNC_UPDATE  = 2'd0;
    localparam logic [1:0] FUNC_DUMP    = 2'd1;
    localparam logic [1:0] FUNC_INSTALL = 2'd2;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_REPLACED = 3'd1;
    localparam logic [2:0] ST_KEPT     = 3'd2;
    localparam logic [2:0] ST_INSERTED = 3'd3;
    localparam logic [2:0] ST_IGNORED  = 3'd4;
    localparam logic [2:0] ST_FULL     = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    typedef struct packed {
        logic [1:0]  func;
        logic [63:0] prefix_hi;
        logic [63:0] prefix_lo;
        logic [7:0]  prefix_length;
        logic [15:0] tag_in;
        logic [7:0]  metric_in;
        logic [1:0]  rx_iface;
    } in_item_t;

    typedef struct packed {
        logic        kind;
        logic [2:0]  status;
        logic [63:0] out_prefix_hi;
        logic [63:0] out_prefix_lo;
        logic [7:0]  out_length;
        logic [15:0] out_tag;
        logic [4:0]  out_metric;
        logic        packet_end;
        logic        last;
    } out_item_t;

    typedef enum logic [1:0] {
        OP_SEARCH,
        OP_DUMP,
        OP_STATUS
    } op_t;

    // classified command handed from front to back
    typedef struct packed {
        op_t         op;
        logic        is_install;
        logic [2:0]  status;
        logic [63:0] prefix_hi;
        logic [63:0] prefix_lo;
        logic [7:0]  prefix_length;
        logic [15:0] tag;
        logic [7:0]  metric;
        logic [1:0]  iface;
    } cmd_t;

    typedef struct packed {
        logic [63:0] prefix_hi;
        logic [63:0] prefix_lo;
        logic [7:0]  length;
        logic [15:0] tag;
        logic [7:0]  metric;
        logic [1:0]  iface;
    } route_t;

endpackage
`default_nettype wire

[design/rrte_ram.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrte_ram
// generic single port ram with registered read
// ----------------------------------------------------------------------------
module rrte_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] addr,
    input  wire logic [WIDTH-1:0]         wdata,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[addr] <= wdata;
        end
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[design/rrte_front.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrte_front
// accepts input transactions, classifies them, two-entry command queue
// ----------------------------------------------------------------------------
module rrte_front
    import rrte_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    output logic          cmd_valid,
    input  wire logic     cmd_take,
    output cmd_t          cmd
);
    cmd_t       q_reg [2];
    logic       rd_reg, wr_reg;
    logic [1:0] cnt_reg;
    cmd_t       c;
    logic       push, pop;
    logic [8:0] m1;

    always_comb
    begin
        m1 = {1'b0, in_data.metric_in} + 9'd1;
        c.is_install    = (in_data.func == FUNC_INSTALL);
        c.status        = ST_IGNORED;
        c.prefix_hi     = in_data.prefix_hi;
        c.prefix_lo     = in_data.prefix_lo;
        c.prefix_length = in_data.prefix_length;
        c.tag           = in_data.tag_in;
        c.iface         = in_data.rx_iface;
        c.metric        = in_data.metric_in;
        c.op            = OP_SEARCH;
        if (in_data.func == FUNC_UPDATE && m1 > {1'b0, INFINITY_METRIC})
        begin
            c.metric = INFINITY_METRIC;
        end
        else if (in_data.func == FUNC_UPDATE)
        begin
            c.metric = m1[7:0];
        end
        if (in_data.func == FUNC_DUMP)
        begin
            c.op = OP_DUMP;
        end
        else if (in_data.func == 2'd3 || {30'd0, in_data.rx_iface} >= NUM_IFACES
                 || (in_data.func == FUNC_UPDATE && in_data.metric_in == NEXTHOP_METRIC))
        begin
            c.op = OP_STATUS;
        end
    end

    assign in_stall  = (cnt_reg == 2'd2);
    assign push      = in_valid && !in_stall;
    assign cmd_valid = (cnt_reg != 2'd0);
    assign pop       = cmd_valid && cmd_take;
    assign cmd       = q_reg[rd_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= c;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_reg  <= 1'b0;
            wr_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= ~wr_reg;
            end
            if (pop)
            begin
                rd_reg <= ~rd_reg;
            end
            cnt_reg <= cnt_reg + {1'b0, push} - {1'b0, pop};
        end
    end

    a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    a_full_stall: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd2 |-> in_stall) else $error("full queue not stalling");
    a_empty_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg == 2'd0 |-> !cmd_valid) else $error("empty queue shows command");
endmodule
`default_nettype wire

[design/rrte_back.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// rrte_back
// walks the route memory to search, update, append or dump; status commands go straight to the output
// ----------------------------------------------------------------------------
module rrte_back
    import rrte_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire logic      cmd_valid,
    output logic           cmd_take,
    input  wire cmd_t      cmd,
    output logic           out_valid,
    input  wire logic      out_stall,
    output out_item_t      out_data
);
    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_CHECK,
        S_EMIT
    } state_t;

    state_t           state_reg;
    cmd_t             cmd_reg;
    logic [CNT_W-1:0] count_reg;
    logic [CNT_W-1:0] idx_reg;
    logic [PKT_W-1:0] pkt_reg;
    logic             out_valid_reg;
    out_item_t        out_reg;

    logic             we;
    logic [IDX_W-1:0] addr;
    route_t           wroute, rroute;
    logic [ROUTE_W-1:0] rdata;
    logic             hit, at_end, out_free;
    logic [4:0]       dm;
    logic             pend;
    logic [2:0]       chk_status;
    out_item_t        dump_item;
    logic             load;

    function automatic out_item_t status_item(input logic [2:0] code);
        out_item_t r;
        begin
            r        = '0;
            r.status = code;
            r.last   = 1'b1;
            return r;
        end
    endfunction

    rrte_ram #(.WIDTH(ROUTE_W), .DEPTH(1 << IDX_W)) u_ram (
        .clk   (clk),
        .we    (we),
        .addr  (addr),
        .wdata (wroute),
        .rdata (rdata)
    );

    assign rroute   = route_t'(rdata);
    assign out_free = !out_valid_reg || !out_stall;
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;
    assign cmd_take  = (state_reg == S_IDLE) && out_free;
    assign at_end    = (idx_reg == count_reg);
    assign hit = rroute.prefix_hi == cmd_reg.prefix_hi && rroute.prefix_lo == cmd_reg.prefix_lo
                 && rroute.length == cmd_reg.prefix_length;
    assign dm  = (rroute.metric > INFINITY_METRIC || rroute.iface == cmd_reg.iface)
                 ? 5'd16 : rroute.metric[4:0];
    assign pend = (pkt_reg == PKT_W'(ENTRIES_PER_PACKET - 1)) || (idx_reg + 1'b1 == count_reg);

    // write happens from S_CHECK on hit or append at the end of a search
    always_comb
    begin
        we     = 1'b0;
        addr   = idx_reg[IDX_W-1:0];
        wroute = rroute;
        if (state_reg == S_CHECK && cmd_reg.op == OP_SEARCH)
        begin
            if (at_end)
            begin
                wroute = '{cmd_reg.prefix_hi, cmd_reg.prefix_lo, cmd_reg.prefix_length,
                           cmd_reg.tag, cmd_reg.metric, cmd_reg.iface};
                we = out_free && (count_reg < CNT_W'(TABLE_DEPTH))
                     && (cmd_reg.is_install || cmd_reg.metric < INFINITY_METRIC);
            end
            else if (hit)
            begin
                we = out_free;
                if (cmd_reg.is_install)
                begin
                    wroute.tag = cmd_reg.tag;
                    wroute.metric = cmd_reg.metric;
                    wroute.iface = cmd_reg.iface;
                end
                else if (rroute.iface == cmd_reg.iface)
                begin
                    wroute.metric = cmd_reg.metric;
                end
                else if (rroute.metric > cmd_reg.metric)
                begin
                    wroute.metric = cmd_reg.metric;
                    wroute.iface = cmd_reg.iface;
                end
                else
                begin
                    we = 1'b0;
                end
            end
        end
    end

    // result of a search step, dumped route and result load
    always_comb
    begin
        chk_status = ST_KEPT;
        if (at_end)
        begin
            if (!cmd_reg.is_install && cmd_reg.metric >= INFINITY_METRIC)
            begin
                chk_status = ST_IGNORED;
            end
            else if (count_reg < CNT_W'(TABLE_DEPTH))
            begin
                chk_status = ST_INSERTED;
            end
            else
            begin
                chk_status = ST_FULL;
            end
        end
        else if (cmd_reg.is_install || rroute.iface == cmd_reg.iface)
        begin
            chk_status = ST_UPDATED;
        end
        else if (rroute.metric > cmd_reg.metric)
        begin
            chk_status = ST_REPLACED;
        end

        dump_item               = '0;
        dump_item.kind          = 1'b1;
        dump_item.status        = ST_UPDATED;
        dump_item.out_prefix_hi = rroute.prefix_hi;
        dump_item.out_prefix_lo = rroute.prefix_lo;
        dump_item.out_length    = rroute.length;
        dump_item.out_tag       = rroute.tag;
        dump_item.out_metric    = dm;
        dump_item.packet_end    = pend;
        dump_item.last          = (idx_reg + 1'b1 == count_reg);

        load = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                load = cmd_valid && out_free
                       && (cmd.op == OP_STATUS || (cmd.op == OP_DUMP && count_reg == '0));
            end
            S_CHECK:
            begin
                load = out_free && (at_end || hit);
            end
            S_EMIT:
            begin
                load = out_free;
            end
            default:
            begin
                load = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd_take && cmd_valid)
        begin
            cmd_reg <= cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            idx_reg       <= '0;
            pkt_reg       <= '0;
            out_valid_reg <= 1'b0;
            out_reg       <= '0;
        end
        else
        begin
            if (load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE:
                begin
                    idx_reg <= '0;
                    pkt_reg <= '0;
                    if (cmd_valid && out_free)
                    begin
                        if (cmd.op == OP_STATUS)
                        begin
                            out_reg <= status_item(cmd.status);
                        end
                        else if (cmd.op == OP_DUMP && count_reg == '0)
                        begin
                            out_reg <= status_item(ST_EMPTY);
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= (cmd_reg.op == OP_DUMP) ? S_EMIT : S_CHECK;
                end
                S_CHECK:
                begin
                    if (at_end || hit)
                    begin
                        if (out_free)
                        begin
                            out_reg <= status_item(chk_status);
                            if (at_end && chk_status == ST_INSERTED)
                            begin
                                count_reg <= count_reg + 1'b1;
                            end
                            state_reg <= S_IDLE;
                        end
                    end
                    else
                    begin
                        idx_reg   <= idx_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_EMIT:
                begin
                    if (out_free)
                    begin
                        out_reg <= dump_item;
                        pkt_reg <= (pkt_reg == PKT_W'(ENTRIES_PER_PACKET - 1))
                                   ? '0 : pkt_reg + 1'b1;
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= (idx_reg + 1'b1 == count_reg) ? S_IDLE : S_READ;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(TABLE_DEPTH)) else $error("entry count beyond depth");
    a_no_write_stall: assert property (@(posedge clk) disable iff (!rst_n)
        we |-> out_free) else $error("table written while result blocked");
    a_take_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_take |-> state_reg == S_IDLE) else $error("command taken while busy");
endmodule
`default_nettype wire

[design/ripng_route_table_engine_top.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// ripng_route_table_engine_top
// RIPng route table: response updates, direct installs and poisoned dumps
// ----------------------------------------------------------------------------
// A route table of up to 64 entries held in one single-port memory. An
// update or install walks the table from entry 0 with an exact match on
// prefix and length, visiting each entry in a read step and a compare step.
// A dump gives one transaction per route, each read and then emitted, with
// a packet boundary every 25 routes and split horizon with poisoned reverse
// toward the target interface. Ignored items and an empty dump give one
// status result at once. The front classifies items into a two-entry queue,
// so input transactions keep being taken, until the queue is full, while
// the back end walks the memory; the result register lets the back end
// finish a walk step while a result is held by stall.
// ----------------------------------------------------------------------------
module ripng_route_table_engine_top
    import rrte_pkg::*;
(
    input  wire logic     clk,
    input  wire logic     rst_n,
    input  wire logic     in_valid,
    output logic          in_stall,
    input  wire in_item_t in_data,
    output logic          out_valid,
    input  wire logic     out_stall,
    output out_item_t     out_data
);
    // command hand-off between front and back
    logic cmd_valid, cmd_take;
    cmd_t cmd;

    rrte_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd)
    );

    rrte_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_take  (cmd_take),
        .cmd       (cmd),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );
endmodule
`default_nettype wire
